@@ hdl/rpab_pkg.sv @@
// Package for the RGBA pixel alpha blend unit: blend mode and register
// index codes, plus the per-channel field extract, place and mix helpers.
// No dependencies.
package rpab_pkg;

  localparam int unsigned PixelWidth = 32;
  localparam int unsigned ChanWidth  = 8;
  localparam int unsigned ShiftWidth = 5;
  localparam int unsigned CfgIdxWidth = 3;

  typedef logic [PixelWidth-1:0] pixel_t;
  typedef logic [ChanWidth-1:0]  chan_t;
  typedef logic [ShiftWidth-1:0] shift_t;

  // Alpha selection for the stored pixel.
  typedef enum logic [2:0] {
    BM_SUM     = 3'd0,  // dst + src, saturated
    BM_SRC     = 3'd1,
    BM_DST     = 3'd2,
    BM_INV_DST = 3'd3,  // 255 - dst
    BM_INV_SRC = 3'd4   // 255 - src
  } blend_mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_RED_SHIFT     = 3'd0,
    CFG_GREEN_SHIFT   = 3'd1,
    CFG_BLUE_SHIFT    = 3'd2,
    CFG_ALPHA_SHIFT   = 3'd3,
    CFG_ALPHA_PRESENT = 3'd4,
    CFG_KEY_ENABLE    = 3'd5,
    CFG_KEY_COLOR     = 3'd6
  } cfg_index_e;

  localparam shift_t RedShiftRst   = 5'd0;
  localparam shift_t GreenShiftRst = 5'd8;
  localparam shift_t BlueShiftRst  = 5'd16;
  localparam shift_t AlphaShiftRst = 5'd24;
  localparam chan_t  ChanMax       = 8'd255;

  // Reads the 8-bit field at bit position sh; bits above bit 31 read as zero.
  function automatic chan_t field_get(input pixel_t px, input shift_t sh);
    pixel_t shifted;
    shifted = px >> sh;
    return shifted[ChanWidth-1:0];
  endfunction

  // Places an 8-bit field at bit position sh; bits beyond bit 31 are dropped.
  function automatic pixel_t field_place(input chan_t v, input shift_t sh);
    pixel_t wide;
    wide = {{(PixelWidth-ChanWidth){1'b0}}, v};
    return wide << sh;
  endfunction

  // d + floor((s - d) * w / 256), taken modulo 256.
  function automatic chan_t mix(input chan_t s, input chan_t d, input chan_t w);
    logic signed [ChanWidth:0]     diff;
    logic signed [2*ChanWidth+1:0] prod;
    logic signed [2*ChanWidth+1:0] quot;
    diff = $signed({1'b0, s}) - $signed({1'b0, d});
    prod = diff * $signed({1'b0, w});
    quot = prod >>> ChanWidth;
    return d + quot[ChanWidth-1:0];
  endfunction

endpackage

@@ hdl/rgba_pixel_alpha_blend_unit.sv @@
// Top level of the RGBA pixel alpha blend unit: input register, blend
// logic and result register. Depends on rpab_pkg.
// A transaction passes through the input register and then the result
// register before it shows on out_valid_o. Throughput: one per clock while
// results are taken; a held result admits one more transaction into stage
// one, then in_ready_o drops. Reset (rst_ni low, asynchronous) empties both
// stages and loads the default layout.
module rgba_pixel_alpha_blend_unit
  import rpab_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [PixelWidth-1:0]  cfg_data_i,
  // Input channel.
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [PixelWidth-1:0]  dst_pixel_i,
  input  logic [ChanWidth-1:0]   src_red_i,
  input  logic [ChanWidth-1:0]   src_green_i,
  input  logic [ChanWidth-1:0]   src_blue_i,
  input  logic [ChanWidth-1:0]   src_alpha_i,
  input  logic [2:0]             blend_mode_i,
  // Output channel.
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [PixelWidth-1:0]  out_pixel_o
);

  // Configuration registers.
  shift_t red_shift_q, green_shift_q, blue_shift_q, alpha_shift_q;
  logic   alpha_present_q, key_enable_q;
  pixel_t key_color_q;

  // The register index is decoded by name; index 7 is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_shift_q     <= RedShiftRst;
      green_shift_q   <= GreenShiftRst;
      blue_shift_q    <= BlueShiftRst;
      alpha_shift_q   <= AlphaShiftRst;
      alpha_present_q <= 1'b1;
      key_enable_q    <= 1'b0;
      key_color_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_RED_SHIFT:     red_shift_q     <= cfg_data_i[ShiftWidth-1:0];
        CFG_GREEN_SHIFT:   green_shift_q   <= cfg_data_i[ShiftWidth-1:0];
        CFG_BLUE_SHIFT:    blue_shift_q    <= cfg_data_i[ShiftWidth-1:0];
        CFG_ALPHA_SHIFT:   alpha_shift_q   <= cfg_data_i[ShiftWidth-1:0];
        CFG_ALPHA_PRESENT: alpha_present_q <= cfg_data_i[0];
        CFG_KEY_ENABLE:    key_enable_q    <= cfg_data_i[0];
        CFG_KEY_COLOR:     key_color_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake. The result register drains whenever it is empty or being
  // taken; the input register moves forward whenever the result register
  // can take its content. Both stages therefore flow every cycle while results
  // are taken, and a held result still lets one more transaction into stage one.
  logic s1_valid_q, s2_valid_q;
  logic s2_ready;

  assign s2_ready    = !s2_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s2_ready;
  assign out_valid_o = s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Stage one: the accepted transaction, held as it arrived.
  pixel_t      s1_dst_q;
  chan_t       s1_red_q, s1_green_q, s1_blue_q, s1_alpha_q;
  blend_mode_e s1_mode_q;

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_dst_q   <= dst_pixel_i;
      s1_red_q   <= src_red_i;
      s1_green_q <= src_green_i;
      s1_blue_q  <= src_blue_i;
      s1_alpha_q <= src_alpha_i;
      s1_mode_q  <= blend_mode_e'(blend_mode_i);
    end
  end

  // Blend logic. A destination that matches the enabled color key is
  // replaced by the source color as it is. Otherwise every color channel
  // moves from the destination toward the source by the source alpha, and
  // the stored alpha is picked by the blend mode.
  logic         key_hit;
  chan_t        dst_red, dst_green, dst_blue, dst_alpha;
  chan_t        new_red, new_green, new_blue, new_alpha;
  logic [ChanWidth:0] alpha_sum;
  pixel_t       alpha_field;
  pixel_t       out_pixel_d;

  always_comb begin
    key_hit   = key_enable_q && (s1_dst_q == key_color_q);
    dst_red   = field_get(s1_dst_q, red_shift_q);
    dst_green = field_get(s1_dst_q, green_shift_q);
    dst_blue  = field_get(s1_dst_q, blue_shift_q);
    // Formats without an alpha field read as fully opaque.
    dst_alpha = alpha_present_q ? field_get(s1_dst_q, alpha_shift_q) : ChanMax;
    alpha_sum = {1'b0, dst_alpha} + {1'b0, s1_alpha_q};

    unique case (s1_mode_q)
      BM_SUM:     new_alpha = alpha_sum[ChanWidth] ? ChanMax : alpha_sum[ChanWidth-1:0];
      BM_SRC:     new_alpha = s1_alpha_q;
      BM_DST:     new_alpha = dst_alpha;
      BM_INV_DST: new_alpha = ChanMax - dst_alpha;
      BM_INV_SRC: new_alpha = ChanMax - s1_alpha_q;
      default:    new_alpha = '0;
    endcase

    if (key_hit) begin
      new_red   = s1_red_q;
      new_green = s1_green_q;
      new_blue  = s1_blue_q;
      new_alpha = s1_alpha_q;
    end else begin
      new_red   = mix(s1_red_q,   dst_red,   s1_alpha_q);
      new_green = mix(s1_green_q, dst_green, s1_alpha_q);
      new_blue  = mix(s1_blue_q,  dst_blue,  s1_alpha_q);
    end

    // Alpha is never packed for a format without an alpha field.
    alpha_field = alpha_present_q ? field_place(new_alpha, alpha_shift_q) : '0;
    out_pixel_d = field_place(new_red, red_shift_q)
                | field_place(new_green, green_shift_q)
                | field_place(new_blue, blue_shift_q)
                | alpha_field;
  end

  // Stage two: the result register.
  pixel_t out_pixel_q;

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      out_pixel_q <= out_pixel_d;
    end
  end

  assign out_pixel_o = out_pixel_q;

  // Input stalls only when both stages are full and the result is held.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s2_valid_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  // An accepted transaction always lands in stage one.
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid_q)
    else $error("accepted transaction lost at stage one");

  // A stage-one transaction that moves forward shows up as a result.
  a_s1_moves_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready) |=> out_valid_o)
    else $error("stage-one transaction lost before the result register");

endmodule
